[design/ebsb_pkg.sv]
// Package for the scaled blend block: widths, operation codes and field layout.
// Used by every module of the block; depends on nothing.
package ebsb_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;

  // The quotient needs DataWidth+FracBits magnitude bits.
  localparam int QuotWidth = DataWidth + FracBits;
  // The intermediate t fits in QuotWidth+1 signed bits.
  localparam int TWidth = QuotWidth + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_mode_t;

  // Register byte addresses.
  localparam logic [3:0] ADDR_OP_MODE = 4'h0;
  localparam logic [3:0] ADDR_ALPHA   = 4'h4;
  localparam logic [3:0] ADDR_BETA    = 4'h8;

  // Sideband carried alongside each word through the pipeline.
  typedef struct packed {
    logic                        div_zero;
    logic                        a_neg;
    logic                        last;
    logic signed [DataWidth-1:0] prior;
  } side_t;

endpackage

[design/ebsb_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, for (|a| << FracBits) / |b|.
// Depends on ebsb_pkg.
module ebsb_divider (
  input  logic                             clk,
  input  logic                             advance,
  input  logic [ebsb_pkg::QuotWidth-1:0]   numer,
  input  logic [ebsb_pkg::DataWidth-1:0]   denom,
  output logic [ebsb_pkg::QuotWidth-1:0]   quot
);
  import ebsb_pkg::*;

  localparam int Steps = QuotWidth;

  logic [QuotWidth-1:0] num_q [Steps+1];
  logic [DataWidth:0]   rem_q [Steps+1];
  logic [DataWidth-1:0] den_q [Steps+1];

  assign num_q[0] = numer;
  assign rem_q[0] = '0;
  assign den_q[0] = denom;

  // Each stage shifts in one numerator bit and subtracts if it can.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [DataWidth:0] shifted;
    logic [DataWidth:0] diff;
    logic               take;
    assign shifted = {rem_q[s][DataWidth-1:0], num_q[s][QuotWidth-1]};
    assign diff    = shifted - {1'b0, den_q[s]};
    assign take    = (shifted >= {1'b0, den_q[s]});
    always_ff @(posedge clk) begin
      if (advance) begin
        rem_q[s+1] <= take ? diff : shifted;
        num_q[s+1] <= {num_q[s][QuotWidth-2:0], take};
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign quot = num_q[Steps];
endmodule

[design/ebsb_delay.sv]
// Delay line that keeps words and sideband aligned with the divider stages.
// Depends on ebsb_pkg.
module ebsb_delay (
  input  logic                           clk,
  input  logic                           advance,
  input  logic signed [ebsb_pkg::TWidth-1:0] t_in,
  input  ebsb_pkg::side_t                side_in,
  output logic signed [ebsb_pkg::TWidth-1:0] t_out,
  output ebsb_pkg::side_t                side_out
);
  import ebsb_pkg::*;

  localparam int Depth = QuotWidth;

  logic signed [TWidth-1:0] t_q    [Depth];
  side_t                    side_q [Depth];

  always_ff @(posedge clk) begin
    if (advance) begin
      t_q[0]    <= t_in;
      side_q[0] <= side_in;
      for (int i = 1; i < Depth; i++) begin
        t_q[i]    <= t_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign t_out    = t_q[Depth-1];
  assign side_out = side_q[Depth-1];
endmodule

[design/ebsb_blend.sv]
// Blend back end: alpha and beta products, rescale, sum and saturate over three stages.
// Depends on ebsb_pkg.
module ebsb_blend (
  input  logic                                 clk,
  input  logic                                 advance,
  input  logic signed [ebsb_pkg::TWidth-1:0]    t_in,
  input  ebsb_pkg::side_t                       side_in,
  input  logic signed [ebsb_pkg::DataWidth-1:0] alpha,
  input  logic signed [ebsb_pkg::DataWidth-1:0] beta,
  output logic signed [ebsb_pkg::DataWidth-1:0] result,
  output logic                                  overflow,
  output logic                                  div_zero,
  output logic                                  last
);
  import ebsb_pkg::*;

  localparam int ProdW = TWidth + DataWidth;
  localparam int SumW  = ProdW + 1;
  localparam int LoW   = 24;
  localparam int HiW   = TWidth - LoW;

  // Stage 1: alpha*t split into two partial products, beta*prior whole.
  logic signed [LoW+DataWidth:0]   pa_lo;
  logic signed [HiW+DataWidth-1:0] pa_hi;
  logic signed [2*DataWidth-1:0]   pb;
  side_t                           side1;
  // Stage 2: assembled and rescaled terms.
  logic signed [SumW-1:0]          u2, v2;
  side_t                           side2;

  logic signed [ProdW-1:0] pa_full;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  max_v, min_v;

  assign pa_full = (ProdW'(pa_hi) <<< LoW) + ProdW'(pa_lo);
  assign sum     = u2 + v2;
  assign max_v   = SumW'({1'b0, {(DataWidth-1){1'b1}}});
  assign min_v   = -max_v - SumW'(1);

  always_ff @(posedge clk) begin
    if (advance) begin
      pa_lo <= alpha * $signed({1'b0, t_in[LoW-1:0]});
      pa_hi <= alpha * $signed(t_in[TWidth-1:LoW]);
      pb    <= side_in.prior * beta;
      side1 <= side_in;
      u2    <= SumW'(pa_full >>> FracBits);
      v2    <= SumW'(pb >>> FracBits);
      side2 <= side1;
      div_zero <= side2.div_zero;
      last     <= side2.last;
      if (side2.div_zero) begin
        result   <= side2.a_neg ? min_v[DataWidth-1:0] : max_v[DataWidth-1:0];
        overflow <= 1'b1;
      end else if (sum > max_v) begin
        result   <= max_v[DataWidth-1:0];
        overflow <= 1'b1;
      end else if (sum < min_v) begin
        result   <= min_v[DataWidth-1:0];
        overflow <= 1'b1;
      end else begin
        result   <= sum[DataWidth-1:0];
        overflow <= 1'b0;
      end
    end
  end
endmodule

[design/elementwise_binary_scaled_blend.sv]
// Top level of the element-wise binary operation with alpha/beta blending.
// Depends on ebsb_pkg, ebsb_divider, ebsb_delay and ebsb_blend.
//
// Usage: words arrive on the s_axis channel carrying a pair of Q16.16
// operands and the prior output element in tdata, with a last flag on tlast.
// Each word yields one word on m_axis with the saturated blend alpha*(a op b) +
// beta*prior, its overflow and divide-by-zero flags, and the last flag.
// The user sets the operation and the two scales through the APB port only while
// the stream is idle, which the block does not enforce; byte addresses 0, 4, 8.
// Throughput is one word per cycle while the receiver takes words. The pipeline
// has one input stage computing the operation, 48 divider stages (one quotient
// bit each, which sets the depth for every mode), a sign-fix stage and three
// blend stages, the last of which is the output register. The whole pipeline
// advances together, so when the receiver stalls every stage holds and
// s_axis_tready falls only when the output register is full and not being
// taken; no word is lost or repeated. Reset clears all valid bits and restores
// op_mode to add, alpha to 1.0 and beta to 0; payload registers are left as
// they are.
module elementwise_binary_scaled_blend (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // first_operand, second_operand, prior_output
  input  logic        s_axis_tlast,  // last_in
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result
  output logic [1:0]  m_axis_tuser,  // overflow, divide_by_zero
  output logic        m_axis_tlast   // last_out
);
  import ebsb_pkg::*;

  localparam int Latency = 1 + QuotWidth + 1 + 3;

  op_mode_t                   op_mode;
  logic signed [DataWidth-1:0] scale_alpha, scale_beta;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode     <= OP_ADD;
      scale_alpha <= DataWidth'(1) <<< FracBits;
      scale_beta  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_OP_MODE: op_mode     <= op_mode_t'(pwdata[1:0]);
        ADDR_ALPHA:   scale_alpha <= pwdata;
        ADDR_BETA:    scale_beta  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_OP_MODE: prdata = {30'd0, op_mode};
      ADDR_ALPHA:   prdata = scale_alpha;
      ADDR_BETA:    prdata = scale_beta;
      default:      prdata = '0;
    endcase
  end

  // One enable for the whole pipeline: it moves unless the output word is held.
  logic advance;
  logic [Latency-1:0] valid;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = valid[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[Latency-2:0], s_axis_tvalid};
    end
  end

  // Input stage: add, subtract, multiply, or divider operands.
  logic signed [DataWidth-1:0] a, b;
  logic signed [2*DataWidth-1:0] prod;
  logic [DataWidth-1:0]          a_mag;
  assign a    = s_axis_tdata[31:0];
  assign b    = s_axis_tdata[63:32];
  assign prod = a * b;
  // Magnitude of a as an unsigned value, so the most negative a gives 2^31.
  assign a_mag = a[DataWidth-1] ? -a : a;

  logic signed [TWidth-1:0] t0;
  side_t                    side0;
  logic [QuotWidth-1:0]     numer0;
  logic [DataWidth-1:0]     denom0;
  logic                     neg0;

  always_ff @(posedge clk) begin
    if (advance) begin
      case (op_mode)
        OP_ADD:  t0 <= TWidth'(a) + TWidth'(b);
        OP_SUB:  t0 <= TWidth'(a) - TWidth'(b);
        OP_MUL:  t0 <= TWidth'(prod >>> FracBits);
        default: t0 <= '0;
      endcase
      numer0 <= {a_mag, {FracBits{1'b0}}};
      denom0 <= b[DataWidth-1] ? -b : b;
      neg0   <= (op_mode == OP_DIV) && (a[DataWidth-1] ^ b[DataWidth-1]);
      side0.div_zero <= (op_mode == OP_DIV) && (b == '0);
      side0.a_neg    <= a[DataWidth-1];
      side0.last     <= s_axis_tlast;
      side0.prior    <= s_axis_tdata[95:64];
    end
  end

  // Divider and the matching delay line.
  logic [QuotWidth-1:0]     quot;
  logic signed [TWidth-1:0] t_d;
  side_t                    side_d;
  logic                     div_d;
  logic                     neg_d;

  ebsb_divider u_div (
    .clk(clk), .advance(advance),
    .numer(numer0), .denom(denom0), .quot(quot)
  );

  // The delay line carries t and the sideband past the divider stages.
  logic signed [TWidth-1:0] t_tag;
  assign t_tag = t0;

  ebsb_delay u_dly (
    .clk(clk), .advance(advance),
    .t_in(t_tag), .side_in(side0),
    .t_out(t_d), .side_out(side_d)
  );

  logic [QuotWidth-1:0] mode_q;
  always_ff @(posedge clk) begin
    if (advance) mode_q <= {mode_q[QuotWidth-2:0], neg0};
  end
  assign neg_d = mode_q[QuotWidth-1];

  logic [QuotWidth-1:0] isdiv_q;
  always_ff @(posedge clk) begin
    if (advance) isdiv_q <= {isdiv_q[QuotWidth-2:0], (op_mode == OP_DIV)};
  end
  assign div_d = isdiv_q[QuotWidth-1];

  // Sign fix and selection of the intermediate.
  logic signed [TWidth-1:0] t1;
  side_t                    side1;
  always_ff @(posedge clk) begin
    if (advance) begin
      if (div_d) begin
        t1 <= neg_d ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      end else begin
        t1 <= t_d;
      end
      side1 <= side_d;
    end
  end

  logic signed [DataWidth-1:0] res;
  logic ov, dz, lst;
  ebsb_blend u_blend (
    .clk(clk), .advance(advance),
    .t_in(t1), .side_in(side1),
    .alpha(scale_alpha), .beta(scale_beta),
    .result(res), .overflow(ov), .div_zero(dz), .last(lst)
  );

  assign m_axis_tdata = res;
  assign m_axis_tuser = {dz, ov};
  assign m_axis_tlast = lst;
endmodule
